>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL of the edge coverage counter map.
// Depends on nothing; the short form expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ECC_ASSERT_CR(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the module's own clk_i and rst_ni.
`define ECC_ASSERT(lbl, prop, msg) \
  `ECC_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/ecc_pkg.sv
// Shared types and constants of the edge coverage counter map.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ecc_pkg;

  // Field and register widths
  localparam int CPU_W      = 8;
  localparam int ADDR_W     = 64;
  localparam int MAP_IDX_W  = 16;
  localparam int CNT_W      = 8;
  localparam int LG_W       = 5;
  localparam int ACT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS   = 2'd1;

  // Configuration reset values
  localparam logic [LG_W-1:0]  MAP_SIZE_LOG2_RST = 5'd16;
  localparam logic [ACT_W-1:0] ACTIVE_CPUS_RST   = 4'd1;

  // SplitMix64 constants
  localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // Controller states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_R1_LL,
    S_R1_HL,
    S_R1_LH,
    S_R2_LL,
    S_R2_HL,
    S_R2_LH,
    S_INDEX,
    S_READ,
    S_UPDATE,
    S_DONE
  } ecc_state_e;

  // Partial product selects of the 64-bit low multiply
  typedef enum logic [1:0] {
    STEP_LL,
    STEP_HL,
    STEP_LH
  } mul_step_e;

  // Controller to datapath
  typedef struct packed {
    logic      clear;     // write zero at the sweep address
    logic      capture;   // take the input transaction
    logic      mul_en;    // accumulate one partial product
    mul_step_e step;
    logic      round;     // 0: first mix multiply, 1: second
    logic      load_x;    // forward the finished product to the mix operand
    logic      idx_load;  // form the map index, store the new previous id
    logic      update;    // write back the incremented counter
    logic      emit;      // load the output register
  } ecc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_ignored;
    logic out_free;
  } ecc_sts_t;

endpackage

>>> hw/rtl/edge_coverage_counter_map_core.sv
// Top level of the edge coverage counter map: configuration registers,
// controller and datapath. Depends on ecc_pkg, ecc_ctrl, ecc_datapath, assert_macros.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid_i/in_ready_o   | cpu_index_i, block_address_i
//  out     | output    | out_valid_o/out_ready_i | ignored_o, map_index_o, hit_count_o
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A counted event runs the hash through the shared 32x32 multiplier, as LL, HL and LH
// partial products for each mix multiply, then forms the index, reads the RAM and writes
// back; an ignored event skips these. A new event is taken only once the result is loaded.
// After reset every entry of the counter RAM is swept to zero, with in_ready_o low.
// A result waits in the output register; a new transaction is taken meanwhile and
// its result stalls only when the register is still full. cfg_ready_o is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module edge_coverage_counter_map_core import ecc_pkg::*; #(
  parameter int MAP_ENTRIES = 65536,
  parameter int NUM_CPUS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [CPU_W-1:0]      cpu_index_i,
  input  logic [ADDR_W-1:0]     block_address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ignored_o,
  output logic [MAP_IDX_W-1:0]  map_index_o,
  output logic [CNT_W-1:0]      hit_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [LG_W-1:0]  map_size_log2_q;
  logic [ACT_W-1:0] active_cpus_q;
  ecc_cmd_t         cmd;
  ecc_sts_t         sts;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_log2_q <= MAP_SIZE_LOG2_RST;
      active_cpus_q   <= ACTIVE_CPUS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAP_SIZE_LOG2: map_size_log2_q <= cfg_data_i[LG_W-1:0];
        CFG_ACTIVE_CPUS:   active_cpus_q   <= cfg_data_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  ecc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ecc_datapath #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .NUM_CPUS    (NUM_CPUS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .map_size_log2_i (map_size_log2_q),
    .active_cpus_i   (active_cpus_q),
    .cpu_index_i     (cpu_index_i),
    .block_address_i (block_address_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .ignored_o       (ignored_o),
    .map_index_o     (map_index_o),
    .hit_count_o     (hit_count_o)
  );

  // No transaction taken while the map is being cleared
  `ECC_ASSERT(a_no_accept_in_clear, cmd.clear |-> !in_ready_o, "input ready during clear")
  // One event in flight at a time
  `ECC_ASSERT(a_single_item, (in_valid_i && in_ready_o) |=> !in_ready_o, "second accept")
  // Dropped events report zero index and count
  `ECC_ASSERT(a_ignored_zero, (out_valid_o && ignored_o) |-> (map_index_o == '0 && hit_count_o == '0), "ignored result not zero")
  // A counted hit is never zero after the increment
  `ECC_ASSERT(a_count_nonzero, (out_valid_o && !ignored_o) |-> (hit_count_o != '0), "zero hit count")

endmodule

>>> hw/rtl/ecc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ecc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ecc_ctrl.sv
// Sequencing state machine of the edge coverage counter map.
// Depends on ecc_pkg; drives the datapath through ecc_cmd_t.
`timescale 1ns / 1ps

module ecc_ctrl import ecc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ecc_sts_t sts_i,
  output ecc_cmd_t cmd_o
);

  ecc_state_e state_q, state_d;

  // State register; reset starts the map clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.step = STEP_LL;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = sts_i.in_ignored ? S_DONE : S_R1_LL;
        end
      end
      S_R1_LL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.step   = STEP_LL;
        state_d      = S_R1_HL;
      end
      S_R1_HL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.step   = STEP_HL;
        state_d      = S_R1_LH;
      end
      S_R1_LH: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.step   = STEP_LH;
        cmd_o.load_x = 1'b1;
        state_d      = S_R2_LL;
      end
      S_R2_LL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.round  = 1'b1;
        cmd_o.step   = STEP_LL;
        state_d      = S_R2_HL;
      end
      S_R2_HL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.round  = 1'b1;
        cmd_o.step   = STEP_HL;
        state_d      = S_R2_LH;
      end
      S_R2_LH: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.round  = 1'b1;
        cmd_o.step   = STEP_LH;
        state_d      = S_INDEX;
      end
      S_INDEX: begin
        cmd_o.idx_load = 1'b1;
        state_d        = S_READ;
      end
      // RAM read data arrives in the cycle after the address
      S_READ: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/ecc_datapath.sv
// Datapath of the edge coverage counter map: hash multiplier, previous ids,
// counter RAM and output register. Depends on ecc_pkg and ecc_ram.
`timescale 1ns / 1ps

module ecc_datapath import ecc_pkg::*; #(
  parameter int MAP_ENTRIES = 65536,
  parameter int NUM_CPUS    = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ecc_cmd_t              cmd_i,
  output ecc_sts_t              sts_o,
  input  logic [LG_W-1:0]       map_size_log2_i,
  input  logic [ACT_W-1:0]      active_cpus_i,
  input  logic [CPU_W-1:0]      cpu_index_i,
  input  logic [ADDR_W-1:0]     block_address_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  ignored_o,
  output logic [MAP_IDX_W-1:0]  map_index_o,
  output logic [CNT_W-1:0]      hit_count_o
);

  localparam int AW     = MAP_ENTRIES > 1 ? $clog2(MAP_ENTRIES) : 1;
  localparam int CIDW   = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
  localparam int MAP_LG = $clog2(MAP_ENTRIES + 1) - 1;

  // Captured transaction
  logic [CPU_W-1:0] cpu_q;
  logic             ign_q;

  // Hash operand and accumulator
  logic [63:0] x_q, acc_q, acc_d;
  logic [63:0] op_a, op_b, prod;
  logic [31:0] mul_a, mul_b;

  // Index and counter
  logic [MAP_IDX_W-1:0] prev_q [NUM_CPUS];
  logic [MAP_IDX_W-1:0] prev_cur, hash16, edge16, mask16, idx_full;
  logic [LG_W-1:0]      lg_eff;
  logic [AW-1:0]        idx_q, clr_q;
  logic [CNT_W-1:0]     rd_data, cnt_d, cnt_q;
  logic [CPU_W:0]       cpu_limit;

  // Output register
  logic                 out_valid_q, out_ign_q;
  logic [MAP_IDX_W-1:0] out_idx_q;
  logic [CNT_W-1:0]     out_cnt_q;

  // Effective CPU limit and ignore check on the incoming transaction
  always_comb begin
    if ({{(CPU_W + 1 - ACT_W){1'b0}}, active_cpus_i} > (CPU_W + 1)'(NUM_CPUS)) begin
      cpu_limit = (CPU_W + 1)'(NUM_CPUS);
    end else begin
      cpu_limit = {{(CPU_W + 1 - ACT_W){1'b0}}, active_cpus_i};
    end
  end

  assign sts_o.in_ignored = {1'b0, cpu_index_i} >= cpu_limit;

  // Shared 32x32 multiplier: one partial product of the 64-bit low product per cycle
  always_comb begin
    op_a = cmd_i.round ? (x_q ^ (x_q >> 27)) : (x_q ^ (x_q >> 30));
    op_b = cmd_i.round ? SM_MUL2 : SM_MUL1;
    case (cmd_i.step)
      STEP_LL: begin
        mul_a = op_a[31:0];
        mul_b = op_b[31:0];
      end
      STEP_HL: begin
        mul_a = op_a[63:32];
        mul_b = op_b[31:0];
      end
      STEP_LH: begin
        mul_a = op_a[31:0];
        mul_b = op_b[63:32];
      end
      default: begin
        mul_a = op_a[31:0];
        mul_b = op_b[31:0];
      end
    endcase
  end

  assign prod  = {32'b0, mul_a} * {32'b0, mul_b};
  assign acc_d = (cmd_i.step == STEP_LL) ? prod : acc_q + {prod[31:0], 32'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cpu_q <= cpu_index_i;
      ign_q <= sts_o.in_ignored;
      x_q   <= block_address_i + SM_GOLDEN;
    end else if (cmd_i.load_x) begin
      x_q <= acc_d;
    end
    if (cmd_i.mul_en) begin
      acc_q <= acc_d;
    end
  end

  // Final xorshift, low 16 bits only; edge and masked map index
  assign hash16   = acc_q[15:0] ^ acc_q[46:31];
  assign prev_cur = prev_q[cpu_q[CIDW-1:0]];
  assign edge16   = {prev_cur[MAP_IDX_W-2:0], 1'b0} ^ hash16;
  assign lg_eff   = (map_size_log2_i > LG_W'(MAP_LG)) ? LG_W'(MAP_LG) : map_size_log2_i;
  assign mask16   = ~({MAP_IDX_W{1'b1}} << lg_eff);
  assign idx_full = edge16 & mask16;

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load) begin
      idx_q <= idx_full[AW-1:0];
    end
    if (cmd_i.update) begin
      cnt_q <= cnt_d;
    end
  end

  // Previous block id per CPU
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        prev_q[i] <= '0;
      end
    end else if (cmd_i.idx_load) begin
      prev_q[cpu_q[CIDW-1:0]] <= hash16;
    end
  end

  // Clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  assign sts_o.clear_last = (clr_q == AW'(MAP_ENTRIES - 1));

  // Saturating increment of the stored counter
  assign cnt_d = (rd_data == CNT_MAX) ? CNT_MAX : rd_data + CNT_W'(1);

  ecc_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAP_ENTRIES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear | cmd_i.update),
    .waddr_i (cmd_i.clear ? clr_q : idx_q),
    .wdata_i (cmd_i.clear ? '0 : cnt_d),
    .raddr_i (idx_q),
    .rdata_o (rd_data)
  );

  // Output register; holds the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_ign_q <= ign_q;
      out_idx_q <= ign_q ? '0 : MAP_IDX_W'(idx_q);
      out_cnt_q <= ign_q ? '0 : cnt_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign ignored_o   = out_ign_q;
  assign map_index_o = out_idx_q;
  assign hit_count_o = out_cnt_q;

endmodule
